@@ rtl/core/um_reu_pkg.sv @@
// Shared types and constants for the register execute unit.
package um_reu_pkg;

  // Field widths
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned REG_CNT  = 8;
  localparam int unsigned REG_AW   = $clog2(REG_CNT);
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LV_W     = 25;
  localparam int unsigned DIV_CW   = $clog2(WORD_W);

  // Stream payload widths (whole bytes)
  localparam int unsigned S_DATA_W = 40;
  localparam int unsigned M_DATA_W = 16;

  // Largest value the output instruction may emit
  localparam logic [WORD_W-1:0] OUT_MAX = 32'd255;

  // Opcodes
  localparam logic [3:0] OP_CMOV  = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_STORE = 4'd2;
  localparam logic [3:0] OP_ADD   = 4'd3;
  localparam logic [3:0] OP_MUL   = 4'd4;
  localparam logic [3:0] OP_DIV   = 4'd5;
  localparam logic [3:0] OP_NAND  = 4'd6;
  localparam logic [3:0] OP_HALT  = 4'd7;
  localparam logic [3:0] OP_MAP   = 4'd8;
  localparam logic [3:0] OP_UNMAP = 4'd9;
  localparam logic [3:0] OP_OUT   = 4'd10;
  localparam logic [3:0] OP_IN    = 4'd11;
  localparam logic [3:0] OP_LOADP = 4'd12;
  localparam logic [3:0] OP_LV    = 4'd13;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_HALTED   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_INVALID  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_DIVZERO  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_OUTRANGE = 3'd4;
  localparam logic [STAT_W-1:0] STAT_SEGMENT  = 3'd5;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_DIV,
    S_WB
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // latch the accepted item
    logic read;    // register file read
    logic exec;    // evaluate and register the operation
    logic step;    // one divider iteration
    logic commit;  // write back and load the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_go;    // item is a divide with non-zero divisor
    logic div_last;  // final divider iteration this cycle
    logic out_free;  // output register can take a result
  } dp_sts_t;

endpackage

@@ rtl/core/um_register_execute_unit.sv @@
// Top level of the register execute unit: controller, datapath and stream ports.
//
// One instruction transfer gives one status transfer, and items are handled one
// at a time. A register-file instruction passes register file read, execute and
// write back, which loads the output register, and the unit takes its next
// transfer in the cycle after that. A divide with a non-zero divisor runs the
// restoring divider between execute and write back, which produces one quotient
// bit a cycle, one for each bit of the word. A new transfer is taken as soon as
// the previous result sits in the output register, even if the sink has not yet
// taken it. That item then waits in write back until the sink takes the earlier
// result, so a sink stall delays it. The output byte is zero whenever out_valid
// is low. Halt sticks until reset.
module um_register_execute_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [um_reu_pkg::S_DATA_W-1:0]     s_tdata,   // instruction[31:0], in_byte[39:32]
  input  logic                                s_tuser,   // in_eof
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [um_reu_pkg::M_DATA_W-1:0]     m_tdata,   // status[2:0], out_byte[10:3], zero
  output logic                                m_tuser    // out_valid
);

  um_reu_pkg::dp_cmd_t               cmd;
  um_reu_pkg::dp_sts_t               sts;
  logic [um_reu_pkg::STAT_W-1:0]     status;
  logic [um_reu_pkg::BYTE_W-1:0]     out_byte;

  um_reu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  um_reu_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .instruction   (s_tdata[31:0]),
    .in_byte       (s_tdata[39:32]),
    .in_eof        (s_tuser),
    .res_valid     (m_tvalid),
    .res_ready     (m_tready),
    .res_status    (status),
    .res_out_valid (m_tuser),
    .res_out_byte  (out_byte)
  );

  // Pack result transfer
  assign m_tdata = {{(um_reu_pkg::M_DATA_W - um_reu_pkg::STAT_W - um_reu_pkg::BYTE_W){1'b0}},
                    out_byte, status};

`ifndef SYNTHESIS
  // One item at a time: no transfer in the cycle after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted on consecutive cycles");

  // An emitted byte only comes with an ok status
  a_emit_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> status == um_reu_pkg::STAT_OK)
    else $error("byte emitted with non-ok status");

  // No emitted byte means a zero byte field
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> out_byte == '0)
    else $error("byte field not zero without emission");

  // A fresh result is only committed when the output slot is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !m_tvalid || m_tready)
    else $error("pending result overwritten");
`endif

endmodule

@@ rtl/core/um_reu_ctrl.sv @@
// Sequencing state machine for the register execute unit.
module um_reu_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  um_reu_pkg::dp_sts_t  sts,
  output um_reu_pkg::dp_cmd_t  cmd
);

  um_reu_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= um_reu_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      um_reu_pkg::S_IDLE: begin
        if (s_tvalid) state_next = um_reu_pkg::S_READ;
      end
      um_reu_pkg::S_READ: begin
        state_next = um_reu_pkg::S_EXEC;
      end
      um_reu_pkg::S_EXEC: begin
        state_next = sts.div_go ? um_reu_pkg::S_DIV : um_reu_pkg::S_WB;
      end
      um_reu_pkg::S_DIV: begin
        if (sts.div_last) state_next = um_reu_pkg::S_WB;
      end
      um_reu_pkg::S_WB: begin
        if (sts.out_free) state_next = um_reu_pkg::S_IDLE;
      end
      default: state_next = um_reu_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      um_reu_pkg::S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      um_reu_pkg::S_READ: cmd.read = 1'b1;
      um_reu_pkg::S_EXEC: cmd.exec = 1'b1;
      um_reu_pkg::S_DIV:  cmd.step = 1'b1;
      um_reu_pkg::S_WB:   cmd.commit = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/core/um_reu_dp.sv @@
// Register file, ALU, iterative divider and result register.
module um_reu_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  um_reu_pkg::dp_cmd_t                   cmd,
  output um_reu_pkg::dp_sts_t                   sts,
  input  logic [um_reu_pkg::WORD_W-1:0]         instruction,
  input  logic [um_reu_pkg::BYTE_W-1:0]         in_byte,
  input  logic                                  in_eof,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output logic [um_reu_pkg::STAT_W-1:0]         res_status,
  output logic                                  res_out_valid,
  output logic [um_reu_pkg::BYTE_W-1:0]         res_out_byte
);

  localparam int unsigned W  = um_reu_pkg::WORD_W;
  localparam int unsigned AW = um_reu_pkg::REG_AW;

  // Latched item
  logic [W-1:0]                   instr_q;
  logic [um_reu_pkg::BYTE_W-1:0]  byte_q;
  logic                           eof_q;

  // Register file: memory plus reset valid bits
  logic [W-1:0]                   mem [um_reu_pkg::REG_CNT];
  logic [um_reu_pkg::REG_CNT-1:0] vld;
  logic [W-1:0]                   rd_b, rd_c;
  logic                           vld_b, vld_c;
  logic [W-1:0]                   vb, vc;

  logic                           halted;

  // Execute stage registers
  logic [W-1:0]                   alu_res;
  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  logic [um_reu_pkg::STAT_W-1:0]  stat_q;
  logic                           ov_q;
  logic [um_reu_pkg::BYTE_W-1:0]  ob_q;
  logic                           halt_set;

  // Divider
  logic [W-1:0]                   rem, quot;
  logic [um_reu_pkg::DIV_CW-1:0]  cnt;
  logic [W:0]                     trial;

  // Execute stage next values
  logic [W-1:0]                   res_d;
  logic                           we_d;
  logic [AW-1:0]                  wa_d;
  logic [um_reu_pkg::STAT_W-1:0]  st_d;
  logic                           ov_d;
  logic [um_reu_pkg::BYTE_W-1:0]  ob_d;
  logic [W-1:0]                   prod;
  logic [W-1:0]                   wr_data;

  logic [3:0]                     op;
  logic [AW-1:0]                  ra, rb, rc, ra_lv;

  assign op    = instr_q[31:28];
  assign ra    = instr_q[8:6];
  assign rb    = instr_q[5:3];
  assign rc    = instr_q[2:0];
  assign ra_lv = instr_q[27:25];

  assign vb = vld_b ? rd_b : '0;
  assign vc = vld_c ? rd_c : '0;

  // Latch the transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      instr_q <= instruction;
      byte_q  <= in_byte;
      eof_q   <= in_eof;
    end
  end

  // Register file read, registered
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_b  <= mem[rb];
      rd_c  <= mem[rc];
      vld_b <= vld[rb];
      vld_c <= vld[rc];
    end
  end

  // Register file write
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.commit && wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Halt flag, sticky until reset
  always_ff @(posedge clk) begin
    if (rst) begin
      halted <= 1'b0;
    end else if (cmd.commit && halt_set) begin
      halted <= 1'b1;
    end
  end

  assign prod = vb * vc;

  // Decode and evaluate
  always_comb begin
    res_d = '0;
    we_d  = 1'b0;
    wa_d  = ra;
    st_d  = um_reu_pkg::STAT_OK;
    ov_d  = 1'b0;
    ob_d  = '0;
    if (halted) begin
      st_d = um_reu_pkg::STAT_HALTED;
    end else begin
      unique case (op) inside
        um_reu_pkg::OP_CMOV: begin
          res_d = vb;
          we_d  = (vc != '0);
        end
        um_reu_pkg::OP_ADD: begin
          res_d = vb + vc;
          we_d  = 1'b1;
        end
        um_reu_pkg::OP_MUL: begin
          res_d = prod;
          we_d  = 1'b1;
        end
        um_reu_pkg::OP_DIV: begin
          if (vc == '0) st_d = um_reu_pkg::STAT_DIVZERO;
          else          we_d = 1'b1;
        end
        um_reu_pkg::OP_NAND: begin
          res_d = ~(vb & vc);
          we_d  = 1'b1;
        end
        um_reu_pkg::OP_HALT: begin
          st_d = um_reu_pkg::STAT_HALTED;
        end
        um_reu_pkg::OP_OUT: begin
          if (vc > um_reu_pkg::OUT_MAX) begin
            st_d = um_reu_pkg::STAT_OUTRANGE;
          end else begin
            ov_d = 1'b1;
            ob_d = vc[um_reu_pkg::BYTE_W-1:0];
          end
        end
        um_reu_pkg::OP_IN: begin
          res_d = eof_q ? '1 : {{(W-um_reu_pkg::BYTE_W){1'b0}}, byte_q};
          wa_d  = rc;
          we_d  = 1'b1;
        end
        um_reu_pkg::OP_LV: begin
          res_d = {{(W-um_reu_pkg::LV_W){1'b0}}, instr_q[um_reu_pkg::LV_W-1:0]};
          wa_d  = ra_lv;
          we_d  = 1'b1;
        end
        um_reu_pkg::OP_LOAD, um_reu_pkg::OP_STORE, um_reu_pkg::OP_MAP,
        um_reu_pkg::OP_UNMAP, um_reu_pkg::OP_LOADP: begin
          st_d = um_reu_pkg::STAT_SEGMENT;
        end
        default: st_d = um_reu_pkg::STAT_INVALID;
      endcase
    end
  end

  // Execute stage registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      alu_res  <= res_d;
      wr_en    <= we_d;
      wr_addr  <= wa_d;
      stat_q   <= st_d;
      ov_q     <= ov_d;
      ob_q     <= ob_d;
      halt_set <= !halted && (op == um_reu_pkg::OP_HALT);
    end
  end

  // Restoring divider, one quotient bit a cycle
  assign trial = {rem, quot[W-1]} - {1'b0, vc};

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rem  <= '0;
      quot <= vb;
      cnt  <= '0;
    end else if (cmd.step) begin
      if (!trial[W]) begin
        rem  <= trial[W-1:0];
        quot <= {quot[W-2:0], 1'b1};
      end else begin
        rem  <= {rem[W-2:0], quot[W-1]};
        quot <= {quot[W-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
    end
  end

  assign wr_data = (op == um_reu_pkg::OP_DIV) ? quot : alu_res;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.commit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_status    <= stat_q;
      res_out_valid <= ov_q;
      res_out_byte  <= ob_q;
    end
  end

  // Status to controller
  assign sts.div_go   = !halted && (op == um_reu_pkg::OP_DIV) && (vc != '0);
  assign sts.div_last = &cnt;
  assign sts.out_free = !res_valid || res_ready;

endmodule

@@ test/tb.sv @@
// Self-checking stream testbench for the UM register execute unit.
module tb;
  import um_reu_pkg::*;

  // Opcodes the unit rejects as invalid
  localparam logic [3:0] OP_BAD_LO = 4'd14;
  localparam logic [3:0] OP_BAD_HI = 4'd15;

  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned HALTED_ITEMS = 24;
  localparam int unsigned QUIET_FROM   = 500;
  localparam int unsigned QUIET_TO     = 700;
  localparam int unsigned IDLE_PCT     = 36;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PRINT_LIMIT  = 60;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              valid;
    logic [BYTE_W-1:0] obyte;
  } result_t;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic [BYTE_W-1:0] ibyte;
    logic              eof;
    bit                typed;  // expected result written into the row
    result_t           want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;   // instruction[31:0], in_byte[39:32]
  logic                s_tuser;   // in_eof
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;   // status[2:0], out_byte[10:3], zero
  logic                m_tuser;   // out_valid

  // Shadow copy of the architectural state
  logic [WORD_W-1:0] regs [REG_CNT];
  bit                is_halted;

  result_t     pending_results[$];
  plan_row_t   plan[$];
  bit          quiet;
  int unsigned n_errors;
  int unsigned n_cycles;

  logic [3:0] seg_ops [5] = '{OP_LOAD, OP_STORE, OP_MAP, OP_UNMAP, OP_LOADP};

  um_register_execute_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Register-to-register instruction word
  function automatic logic [WORD_W-1:0] rop(logic [3:0] op, logic [2:0] a, logic [2:0] b,
                                            logic [2:0] c);
    return {op, 19'd0, a, b, c};
  endfunction

  // Load value instruction word
  function automatic logic [WORD_W-1:0] lv(logic [2:0] a, logic [LV_W-1:0] value);
    return {OP_LV, a, value};
  endfunction

  function automatic plan_row_t row(logic [WORD_W-1:0] w, logic [BYTE_W-1:0] b, logic e,
                                    bit typed, logic [STAT_W-1:0] st, logic v,
                                    logic [BYTE_W-1:0] ob);
    plan_row_t r;
    r.word  = w;
    r.ibyte = b;
    r.eof   = e;
    r.typed = typed;
    r.want  = '{st, v, ob};
    return r;
  endfunction

  // Mostly well-formed register traffic; some segment, invalid and noise words
  function automatic logic [WORD_W-1:0] random_instr(bit any_op);
    logic [WORD_W-1:0] w;
    int unsigned       pick;
    w    = $urandom;
    pick = $urandom_range(99);
    if (pick < 18) begin
      w[31:28] = OP_LV;
      if ($urandom_range(1)) w[LV_W-1:0] = LV_W'($urandom_range(300));
    end else if (pick < 30) w[31:28] = OP_IN;
    else if (pick < 40) w[31:28] = OP_DIV;
    else if (pick < 48) w[31:28] = OP_ADD;
    else if (pick < 56) w[31:28] = OP_MUL;
    else if (pick < 64) w[31:28] = OP_NAND;
    else if (pick < 72) w[31:28] = OP_CMOV;
    else if (pick < 84) w[31:28] = OP_OUT;
    else if (pick < 90) w[31:28] = seg_ops[$urandom_range(4)];
    else if (pick < 94) w[31:28] = $urandom_range(1) ? OP_BAD_LO : OP_BAD_HI;
    else if (!any_op && w[31:28] == OP_HALT) w[31:28] = OP_NAND;
    return w;
  endfunction

  // Executes one instruction on the shadow state and returns its status transfer
  task automatic um_execute(input logic [WORD_W-1:0] w, input logic [BYTE_W-1:0] b,
                            input logic e, output result_t r);
    logic [3:0]        op;
    logic [2:0]        ra, rb, rc;
    logic [WORD_W-1:0] vb, vc;
    op = w[31:28];
    ra = w[8:6];
    rb = w[5:3];
    rc = w[2:0];
    r  = '{STAT_OK, 1'b0, '0};
    if (is_halted) begin
      r.status = STAT_HALTED;
    end else begin
      vb = regs[rb];
      vc = regs[rc];
      case (op)
        OP_CMOV: if (vc != '0) regs[ra] = vb;
        OP_ADD:  regs[ra] = vb + vc;
        OP_MUL:  regs[ra] = vb * vc;
        OP_DIV: begin
          if (vc == '0) r.status = STAT_DIVZERO;
          else regs[ra] = vb / vc;
        end
        OP_NAND: regs[ra] = ~(vb & vc);
        OP_HALT: begin
          is_halted = 1'b1;
          r.status  = STAT_HALTED;
        end
        OP_OUT: begin
          if (vc > OUT_MAX) begin
            r.status = STAT_OUTRANGE;
          end else begin
            r.valid = 1'b1;
            r.obyte = vc[BYTE_W-1:0];
          end
        end
        OP_IN:   regs[rc] = e ? '1 : WORD_W'(b);
        OP_LV:   regs[w[27:25]] = WORD_W'(w[LV_W-1:0]);
        OP_LOAD, OP_STORE, OP_MAP, OP_UNMAP, OP_LOADP: r.status = STAT_SEGMENT;
        default: r.status = STAT_INVALID;
      endcase
    end
  endtask

  // Offers one instruction transfer and records its expected result on acceptance
  task automatic send(input logic [WORD_W-1:0] w, input logic [BYTE_W-1:0] b, input logic e,
                      input bit typed, input result_t want);
    result_t r;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, w};
    s_tuser  <= e;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    um_execute(w, b, e, r);
    pending_results.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic mismatch(input string field, input int unsigned want, input int unsigned got);
    n_errors++;
    if (n_errors <= PRINT_LIMIT)
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
  endtask

  // Sink side back-pressure
  always @(negedge clk) begin
    m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // Result checker
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= PRINT_LIMIT)
          $display("%0t: unexpected result, actual status %0d", $time, m_tdata[2:0]);
      end else begin
        exp_r = pending_results.pop_front();
        if (m_tdata[2:0] !== exp_r.status) mismatch("status", exp_r.status, m_tdata[2:0]);
        if (m_tuser !== exp_r.valid) mismatch("out_valid", exp_r.valid, m_tuser);
        if (m_tdata[10:3] !== exp_r.obyte) mismatch("out_byte", exp_r.obyte, m_tdata[10:3]);
        if (m_tdata[M_DATA_W-1:11] !== '0) mismatch("padding", 0, m_tdata[M_DATA_W-1:11]);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    m_tready  = 1'b0;
    quiet     = 1'b0;
    n_errors  = 0;
    n_cycles  = 0;
    is_halted = 1'b0;
    foreach (regs[i]) regs[i] = '0;

    // Directed rows: all registers start at zero
    plan.push_back(row(rop(OP_OUT, 0, 0, 0), 8'h00, 1'b0, 1, STAT_OK, 1'b1, 8'd0));
    plan.push_back(row(rop(OP_DIV, 1, 0, 0), 8'h00, 1'b0, 1, STAT_DIVZERO, 1'b0, 8'd0));
    plan.push_back(row({OP_BAD_LO, 28'd0}, 8'h00, 1'b0, 1, STAT_INVALID, 1'b0, 8'd0));
    plan.push_back(row('1, 8'hFF, 1'b1, 1, STAT_INVALID, 1'b0, 8'd0));
    foreach (seg_ops[i])
      plan.push_back(row(rop(seg_ops[i], 3'd7, 3'd5, 3'd2), 8'h00, 1'b0, 1, STAT_SEGMENT,
                         1'b0, 8'd0));
    plan.push_back(row(lv(1, '1), 8'h00, 1'b0, 1, STAT_OK, 1'b0, 8'd0));
    plan.push_back(row(lv(2, '0), 8'h00, 1'b0, 1, STAT_OK, 1'b0, 8'd0));
    plan.push_back(row(lv(3, 25'd7), 8'h00, 1'b0, 1, STAT_OK, 1'b0, 8'd0));
    plan.push_back(row(rop(OP_IN, 0, 0, 4), 8'hFF, 1'b0, 1, STAT_OK, 1'b0, 8'd0));
    // end of input: byte is ignored, register gets all ones
    plan.push_back(row(rop(OP_IN, 0, 0, 5), 8'hAA, 1'b1, 1, STAT_OK, 1'b0, 8'd0));
    plan.push_back(row(rop(OP_OUT, 0, 0, 5), 8'h00, 1'b0, 1, STAT_OUTRANGE, 1'b0, 8'd0));
    plan.push_back(row(rop(OP_OUT, 0, 0, 4), 8'h00, 1'b0, 1, STAT_OK, 1'b1, 8'hFF));
    plan.push_back(row(rop(OP_ADD, 6, 5, 5), 8'h00, 1'b0, 0, STAT_OK, 1'b0, 8'd0));
    plan.push_back(row(rop(OP_MUL, 7, 5, 5), 8'h00, 1'b0, 0, STAT_OK, 1'b0, 8'd0));
    plan.push_back(row(rop(OP_DIV, 6, 5, 3), 8'h00, 1'b0, 0, STAT_OK, 1'b0, 8'd0));
    plan.push_back(row(rop(OP_NAND, 0, 5, 5), 8'h00, 1'b0, 0, STAT_OK, 1'b0, 8'd0));
    plan.push_back(row(rop(OP_CMOV, 1, 4, 2), 8'h00, 1'b0, 0, STAT_OK, 1'b0, 8'd0));
    plan.push_back(row(rop(OP_CMOV, 1, 4, 3), 8'h00, 1'b0, 0, STAT_OK, 1'b0, 8'd0));
    plan.push_back(row(rop(OP_OUT, 0, 0, 1), 8'h00, 1'b0, 0, STAT_OK, 1'b0, 8'd0));
    plan.push_back(row(rop(OP_DIV, 0, 1, 2), 8'h00, 1'b0, 1, STAT_DIVZERO, 1'b0, 8'd0));
    plan.push_back(row(rop(OP_OUT, 0, 0, 7), 8'h00, 1'b0, 0, STAT_OK, 1'b0, 8'd0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) send(plan[i].word, plan[i].ibyte, plan[i].eof, plan[i].typed, plan[i].want);

    // Random register traffic, halt held back so the state stays live
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= QUIET_FROM) && (i < QUIET_TO);
      send(random_instr(1'b0), 8'($urandom), ($urandom_range(9) == 0), 0, '0);
    end
    quiet = 1'b0;

    // Halt sticks: every later transfer reports halted
    send(rop(OP_HALT, 3'd2, 3'd6, 3'd1), 8'h00, 1'b0, 1, '{STAT_HALTED, 1'b0, 8'd0});
    for (int unsigned i = 0; i < HALTED_ITEMS; i++)
      send(random_instr(1'b1), 8'($urandom), ($urandom_range(1) == 0), 0, '0);
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
